// File: hw/rtl/dfmm_pkg.sv
// Shared constants, types and helper functions for the disk-full message matcher.
package dfmm_pkg;

    localparam int WINDOW_LEN_DEF = 24;
    localparam int NUM_MARKERS = 6;
    localparam int MARKER_MAX_LEN = 24;

    localparam logic [6:0] ERROR_CODE_RESET = 7'd28;
    localparam logic [7:0] VALUE_SAT = 8'd255;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_CASE_OFFSET = 8'h20;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // The newest character sits in the low byte; unused upper bytes are zero.
    localparam logic [8*MARKER_MAX_LEN-1:0] MARKER_TEXT [NUM_MARKERS] = '{
        (8*MARKER_MAX_LEN)'("no space left on device"),
        (8*MARKER_MAX_LEN)'("not enough space"),
        (8*MARKER_MAX_LEN)'("database or disk is full"),
        (8*MARKER_MAX_LEN)'("disk full"),
        (8*MARKER_MAX_LEN)'("full disk"),
        (8*MARKER_MAX_LEN)'("enospc")
    };
    localparam int MARKER_LEN [NUM_MARKERS] = '{23, 16, 24, 9, 9, 6};

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] ch;
    } step_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c + CHAR_CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
    endfunction

endpackage

// File: hw/rtl/dfmm_window.sv
// Sliding character window with the parallel marker comparators.
module dfmm_window #(
    parameter int WINDOW_LEN = dfmm_pkg::WINDOW_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dfmm_pkg::step_t step,
    output logic            hit
);
    import dfmm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW_LEN - 1);

    logic [7:0]       recent_reg [WINDOW_LEN-1];
    logic [CNT_W-1:0] chars_seen_reg;
    logic [7:0]       win [WINDOW_LEN];

    always_comb
    begin
        logic ok;
        hit = 1'b0;
        win[0] = step.ch;
        for (int k = 1; k < WINDOW_LEN; k++)
        begin
            win[k] = recent_reg[k-1];
        end
        for (int m = 0; m < NUM_MARKERS; m++)
        begin
            ok = (int'(chars_seen_reg) >= MARKER_LEN[m] - 1);
            for (int j = 0; j < MARKER_MAX_LEN; j++)
            begin
                if (j < MARKER_LEN[m] && win[j] != MARKER_TEXT[m][8*j +: 8])
                begin
                    ok = 1'b0;
                end
            end
            hit = hit | ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg <= '0;
            for (int k = 0; k < WINDOW_LEN - 1; k++)
            begin
                recent_reg[k] <= '0;
            end
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                chars_seen_reg <= '0;
                for (int k = 0; k < WINDOW_LEN - 1; k++)
                begin
                    recent_reg[k] <= '0;
                end
            end
            else
            begin
                if (chars_seen_reg != CNT_MAX)
                begin
                    chars_seen_reg <= chars_seen_reg + 1'b1;
                end
                recent_reg[0] <= step.ch;
                for (int k = 1; k < WINDOW_LEN - 1; k++)
                begin
                    recent_reg[k] <= recent_reg[k-1];
                end
            end
        end
    end

endmodule

// File: hw/rtl/dfmm_parse.sv
// Leading integer parser with saturation and the error code comparison.
module dfmm_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  dfmm_pkg::step_t step,
    input  logic [6:0]      error_code,
    output logic            number_match
);
    import dfmm_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       negative_reg;
    logic       negative_next;
    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic [7:0] digit;
    logic [11:0] product;
    logic       have_number;

    assign digit = step.ch - CHAR_DIGIT_0;
    assign product = {4'd0, value_reg} * 12'd10 + {4'd0, digit};

    always_comb
    begin
        phase_next = phase_reg;
        negative_next = negative_reg;
        value_next = value_reg;
        case (phase_reg)
            PH_SKIP, PH_SIGN:
            begin
                if (phase_reg == PH_SKIP && is_space(step.ch))
                begin
                    phase_next = PH_SKIP;
                end
                else if (phase_reg == PH_SKIP &&
                         (step.ch == CHAR_PLUS || step.ch == CHAR_MINUS))
                begin
                    negative_next = (step.ch == CHAR_MINUS);
                    phase_next = PH_SIGN;
                end
                else if (is_digit(step.ch))
                begin
                    value_next = digit;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    value_next = VALUE_SAT;
                    phase_next = PH_STOP;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(step.ch))
                begin
                    value_next = (product > 12'(VALUE_SAT)) ? VALUE_SAT : product[7:0];
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign have_number = (phase_next == PH_DIGITS || phase_next == PH_STOP) &&
                         (value_next != VALUE_SAT);
    assign number_match = have_number && (value_next == {1'b0, error_code}) &&
                          (!negative_next || value_next == 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            negative_reg <= 1'b0;
            value_reg <= '0;
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                phase_reg <= PH_SKIP;
                negative_reg <= 1'b0;
                value_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                negative_reg <= negative_next;
                value_reg <= value_next;
            end
        end
    end

endmodule

// File: hw/rtl/disk_full_message_matcher_core.sv
// Top level of the disk-full message matcher: input register, result register and control.
// Messages stream in one character per transaction and a new character is taken every
// cycle unless the input side stalls. In the input register the folded character is
// compared against all markers in parallel and the leading number is updated; the
// verdict for a message is registered in the result register when its last character
// leaves the input register. The input side stalls only while a last character waits
// for the result register to empty. error_code may be rewritten through the config port
// between messages; cfg_ready is always high.
module disk_full_message_matcher_core #(
    parameter int WINDOW_LEN = dfmm_pkg::WINDOW_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       disk_full,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);
    import dfmm_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_fire;
    logic       out_free;
    logic       in_accept;
    logic       out_valid_reg;
    logic       disk_full_reg;
    logic       marker_found_reg;
    logic [6:0] error_code_reg;
    logic       hit;
    logic       number_match;
    step_t      step;

    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    assign step.fire = s1_fire;
    assign step.last = s1_last_reg;
    assign step.ch = fold_char(s1_char_reg);

    dfmm_window #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_window (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .hit  (hit)
    );

    dfmm_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .error_code  (error_code_reg),
        .number_match(number_match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            marker_found_reg <= 1'b0;
            error_code_reg <= ERROR_CODE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                error_code_reg <= cfg_data;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                marker_found_reg <= s1_last_reg ? 1'b0 : (marker_found_reg | hit);
            end
            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_char;
        end
        if (s1_fire && s1_last_reg)
        begin
            disk_full_reg <= marker_found_reg | hit | number_match;
        end
    end

    assign out_valid = out_valid_reg;
    assign disk_full = disk_full_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> out_valid_reg)
    else $error("Last character processed without producing a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_last_reg && out_valid_reg)
    else $error("Input stalled while no last character was waiting on the result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> !marker_found_reg)
    else $error("Marker flag not cleared after the end of a message.");

endmodule
